[hw/rtl/tun_pkg.sv]
// ----------------------------------------------------------------------------
// tun_pkg: shared types and constants of the triangle unit normal block
// Beat structures, fixed field widths and the per-item control group that
// travels alongside the data through the pipeline and the cell chains.
// ----------------------------------------------------------------------------
package tun_pkg;

    // Width of one vertex coordinate, fixed by the input beat.
    localparam int COORD_WIDTH = 32;
    // Default number of fraction bits of the normal components.
    localparam int NORMAL_FRAC_BITS_DEF = 30;
    // Width of one normal component in the result beat.
    localparam int OUT_W = 32;
    // Length of the largest component after block normalisation.
    localparam int RED_W = 31;
    // Width of the sum of squares and of its integer square root.
    localparam int SUM_W = 2 * RED_W + 2;
    localparam int ROOT_W = SUM_W / 2;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] vertex_a_x;
        logic signed [COORD_WIDTH-1:0] vertex_a_y;
        logic signed [COORD_WIDTH-1:0] vertex_a_z;
        logic signed [COORD_WIDTH-1:0] vertex_b_x;
        logic signed [COORD_WIDTH-1:0] vertex_b_y;
        logic signed [COORD_WIDTH-1:0] vertex_b_z;
        logic signed [COORD_WIDTH-1:0] vertex_c_x;
        logic signed [COORD_WIDTH-1:0] vertex_c_y;
        logic signed [COORD_WIDTH-1:0] vertex_c_z;
    } tun_in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] normal_x;
        logic signed [OUT_W-1:0] normal_y;
        logic signed [OUT_W-1:0] normal_z;
        logic                    degenerate;
    } tun_out_t;

    // Control group of one item in flight.
    typedef struct packed {
        logic       valid;
        logic       degen;
        logic [2:0] neg;
    } tun_ctl_t;

endpackage

[hw/rtl/tun_front.sv]
// ----------------------------------------------------------------------------
// tun_front: cross product and block normalisation
// Forms the edge vectors, their exact cross product, finds the common
// length of the three components, reduces them to RED_W bits and sums
// their squares. Thirteen register stages, all advancing on en.
// ----------------------------------------------------------------------------
module tun_front (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  logic                                  in_vld,
    input  tun_pkg::tun_in_t                      in_data,
    output tun_pkg::tun_ctl_t                     ctl_out,
    output logic [2:0][tun_pkg::RED_W-1:0]        r_out,
    output logic [tun_pkg::SUM_W-1:0]             s_out
);

    localparam int CW   = tun_pkg::COORD_WIDTH;
    localparam int RB   = tun_pkg::RED_W;
    localparam int EW   = CW + 1;
    localparam int EMW  = CW;
    localparam int LOW  = EMW / 2;
    localparam int HIW  = EMW - LOW;
    localparam int PPW  = 2 * HIW;
    localparam int PW   = 2 * EMW;
    localparam int MW   = PW + 1;
    localparam int NW   = MW + 1;
    localparam int NCH  = (MW + 7) / 8;
    localparam int LENW = $clog2(MW + 1);
    localparam int SHW  = MW + RB;
    localparam int SQW  = 2 * RB;
    localparam int NST  = 13;

    // Operand pairs of the six products: edge index of each factor.
    localparam int PA [6] = '{1, 2, 2, 0, 0, 1};
    localparam int PB [6] = '{5, 4, 3, 5, 4, 3};

    function automatic logic [3:0] len8(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (v[i]) begin
                n = 4'(i + 1);
            end
        end
        return n;
    endfunction

    logic [NST-1:0] vld_reg;

    logic signed [EW-1:0]  e_reg     [6];
    logic [EMW-1:0]        emag_reg  [6];
    logic [5:0]            esg_reg;
    logic [PPW-1:0]        pp_reg    [6][4];
    logic [5:0]            psg3_reg;
    logic [PW-1:0]         pm_reg    [6];
    logic [5:0]            psg4_reg;
    logic signed [NW-1:0]  sp_reg    [6];
    logic signed [NW-1:0]  n_reg     [3];
    logic [MW-1:0]         nm7_reg   [3];
    logic [MW-1:0]         nm8_reg   [3];
    logic [MW-1:0]         nm9_reg   [3];
    logic [NCH-1:0]        cflag_reg;
    logic [3:0]            cloc_reg  [NCH];
    logic [LENW-1:0]       len_reg;
    logic [2:0]            lenlo_reg;
    logic [SHW-1:0]        w10_reg   [3];
    logic [RB-1:0]         r11_reg   [3];
    logic [RB-1:0]         r12_reg   [3];
    logic [RB-1:0]         r13_reg   [3];
    logic [SQW-1:0]        sq_reg    [3];
    logic [tun_pkg::SUM_W-1:0] s_reg;
    logic [2:0]            neg_reg   [7:13];
    logic                  degen_reg [9:13];

    logic signed [CW-1:0]  vtx [9];
    logic [NCH*8-1:0]      orw;
    logic [LENW-1:0]       len_calc;

    assign vtx[0] = in_data.vertex_a_x;
    assign vtx[1] = in_data.vertex_a_y;
    assign vtx[2] = in_data.vertex_a_z;
    assign vtx[3] = in_data.vertex_b_x;
    assign vtx[4] = in_data.vertex_b_y;
    assign vtx[5] = in_data.vertex_b_z;
    assign vtx[6] = in_data.vertex_c_x;
    assign vtx[7] = in_data.vertex_c_y;
    assign vtx[8] = in_data.vertex_c_z;

    // Combined magnitude word, split into byte chunks for the length search.
    always_comb begin
        orw = (NCH * 8)'(nm7_reg[0] | nm7_reg[1] | nm7_reg[2]);
    end

    // Highest non-empty chunk decides the common length.
    always_comb begin
        len_calc = '0;
        for (int c = 0; c < NCH; c++) begin
            if (cflag_reg[c]) begin
                len_calc = LENW'(c * 8) + LENW'(cloc_reg[c]);
            end
        end
    end

    // Item valid chain.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], in_vld};
        end
    end

    // Data path stages.
    always_ff @(posedge aclk) begin
        if (en) begin
            // Edge vectors a - b and a - c.
            for (int k = 0; k < 3; k++) begin
                e_reg[k]     <= EW'(vtx[k]) - EW'(vtx[k + 3]);
                e_reg[k + 3] <= EW'(vtx[k]) - EW'(vtx[k + 6]);
            end
            // Sign and magnitude of each edge component.
            for (int k = 0; k < 6; k++) begin
                esg_reg[k]  <= e_reg[k][EW-1];
                emag_reg[k] <= e_reg[k][EW-1] ? EMW'(-e_reg[k]) : EMW'(e_reg[k]);
            end
            // Half-width partial products of the six magnitudes.
            for (int k = 0; k < 6; k++) begin
                pp_reg[k][0] <= PPW'(emag_reg[PA[k]][LOW-1:0]) *
                                PPW'(emag_reg[PB[k]][LOW-1:0]);
                pp_reg[k][1] <= PPW'(emag_reg[PA[k]][LOW-1:0]) *
                                PPW'(emag_reg[PB[k]][EMW-1:LOW]);
                pp_reg[k][2] <= PPW'(emag_reg[PA[k]][EMW-1:LOW]) *
                                PPW'(emag_reg[PB[k]][LOW-1:0]);
                pp_reg[k][3] <= PPW'(emag_reg[PA[k]][EMW-1:LOW]) *
                                PPW'(emag_reg[PB[k]][EMW-1:LOW]);
                psg3_reg[k]  <= esg_reg[PA[k]] ^ esg_reg[PB[k]];
            end
            // Recombine the partial products.
            for (int k = 0; k < 6; k++) begin
                pm_reg[k]   <= PW'(pp_reg[k][0])
                             + (PW'(pp_reg[k][1]) << LOW)
                             + (PW'(pp_reg[k][2]) << LOW)
                             + (PW'(pp_reg[k][3]) << (2 * LOW));
                psg4_reg[k] <= psg3_reg[k];
            end
            // Signed products.
            for (int k = 0; k < 6; k++) begin
                sp_reg[k] <= psg4_reg[k] ? -$signed(NW'(pm_reg[k])) : $signed(NW'(pm_reg[k]));
            end
            // Cross product components.
            for (int k = 0; k < 3; k++) begin
                n_reg[k] <= sp_reg[2 * k] - sp_reg[2 * k + 1];
            end
            // Sign and magnitude of the components.
            for (int k = 0; k < 3; k++) begin
                neg_reg[7][k] <= n_reg[k][NW-1];
                nm7_reg[k]    <= n_reg[k][NW-1] ? MW'(-n_reg[k]) : MW'(n_reg[k]);
            end
            // Per-chunk occupancy and local length.
            for (int c = 0; c < NCH; c++) begin
                cflag_reg[c] <= |orw[c*8 +: 8];
                cloc_reg[c]  <= len8(orw[c*8 +: 8]);
            end
            nm8_reg    <= nm7_reg;
            neg_reg[8] <= neg_reg[7];
            // Common length; a zero length marks a degenerate face.
            len_reg      <= len_calc;
            degen_reg[9] <= (len_calc == '0);
            nm9_reg      <= nm8_reg;
            neg_reg[9]   <= neg_reg[8];
            // Coarse right shift of mag * 2^RB by whole bytes of the length.
            for (int k = 0; k < 3; k++) begin
                w10_reg[k] <= {nm9_reg[k], {RB{1'b0}}} >> {len_reg[LENW-1:3], 3'b000};
            end
            lenlo_reg     <= len_reg[2:0];
            degen_reg[10] <= degen_reg[9];
            neg_reg[10]   <= neg_reg[9];
            // Fine shift leaves the reduced components.
            for (int k = 0; k < 3; k++) begin
                r11_reg[k] <= RB'(w10_reg[k] >> lenlo_reg);
            end
            degen_reg[11] <= degen_reg[10];
            neg_reg[11]   <= neg_reg[10];
            // Squares.
            for (int k = 0; k < 3; k++) begin
                sq_reg[k] <= SQW'(r11_reg[k]) * SQW'(r11_reg[k]);
            end
            r12_reg       <= r11_reg;
            degen_reg[12] <= degen_reg[11];
            neg_reg[12]   <= neg_reg[11];
            // Sum of squares.
            s_reg <= tun_pkg::SUM_W'(sq_reg[0]) + tun_pkg::SUM_W'(sq_reg[1])
                   + tun_pkg::SUM_W'(sq_reg[2]);
            r13_reg       <= r12_reg;
            degen_reg[13] <= degen_reg[12];
            neg_reg[13]   <= neg_reg[12];
        end
    end

    assign ctl_out.valid = vld_reg[NST-1];
    assign ctl_out.degen = degen_reg[13];
    assign ctl_out.neg   = neg_reg[13];
    assign s_out         = s_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            r_out[k] = r13_reg[k];
        end
    end

endmodule

[hw/rtl/tun_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// tun_sqrt_cell: one digit of the integer square root
// Brings down the next two bits of the radicand, tries the trial divisor
// and settles one bit of the root. The reduced components ride along.
// ----------------------------------------------------------------------------
module tun_sqrt_cell (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  tun_pkg::tun_ctl_t                  ctl_in,
    input  logic [tun_pkg::SUM_W-1:0]          s_in,
    input  logic [tun_pkg::ROOT_W+1:0]         rem_in,
    input  logic [tun_pkg::ROOT_W-1:0]         root_in,
    input  logic [2:0][tun_pkg::RED_W-1:0]     r_in,
    output tun_pkg::tun_ctl_t                  ctl_out,
    output logic [tun_pkg::SUM_W-1:0]          s_out,
    output logic [tun_pkg::ROOT_W+1:0]         rem_out,
    output logic [tun_pkg::ROOT_W-1:0]         root_out,
    output logic [2:0][tun_pkg::RED_W-1:0]     r_out
);

    localparam int QW  = tun_pkg::ROOT_W;
    localparam int RMW = QW + 2;

    tun_pkg::tun_ctl_t           ctl_reg;
    logic [tun_pkg::SUM_W-1:0]   s_reg;
    logic [RMW-1:0]              rem_reg;
    logic [QW-1:0]               root_reg;
    logic [2:0][tun_pkg::RED_W-1:0] r_reg;

    logic [RMW+1:0] cur;
    logic [RMW+1:0] trial;
    logic           fits;

    // Trial subtraction of 4 * root + 1.
    always_comb begin
        cur   = {rem_in, s_in[tun_pkg::SUM_W-1 -: 2]};
        trial = (RMW + 2)'({root_in, 2'b01});
        fits  = (cur >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg    <= s_in << 2;
            r_reg    <= r_in;
            rem_reg  <= fits ? RMW'(cur - trial) : RMW'(cur);
            root_reg <= {root_in[QW-2:0], fits};
        end
    end

    assign ctl_out  = ctl_reg;
    assign s_out    = s_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign r_out    = r_reg;

endmodule

[hw/rtl/tun_div_cell.sv]
// ----------------------------------------------------------------------------
// tun_div_cell: one quotient bit of the three-lane restoring divider
// Each lane shifts in the next numerator bit, compares the partial
// remainder with the root and settles one quotient bit.
// ----------------------------------------------------------------------------
module tun_div_cell #(
    parameter int NORMAL_FRAC_BITS = tun_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  tun_pkg::tun_ctl_t                   ctl_in,
    input  logic [tun_pkg::ROOT_W-1:0]          q_in,
    input  logic [2:0][tun_pkg::ROOT_W-1:0]     rem_in,
    input  logic [2:0][NORMAL_FRAC_BITS:0]      low_in,
    input  logic [2:0][NORMAL_FRAC_BITS:0]      quo_in,
    output tun_pkg::tun_ctl_t                   ctl_out,
    output logic [tun_pkg::ROOT_W-1:0]          q_out,
    output logic [2:0][tun_pkg::ROOT_W-1:0]     rem_out,
    output logic [2:0][NORMAL_FRAC_BITS:0]      low_out,
    output logic [2:0][NORMAL_FRAC_BITS:0]      quo_out
);

    localparam int QW  = tun_pkg::ROOT_W;
    localparam int DQW = NORMAL_FRAC_BITS + 1;

    tun_pkg::tun_ctl_t        ctl_reg;
    logic [QW-1:0]            q_reg;
    logic [2:0][QW-1:0]       rem_reg;
    logic [2:0][DQW-1:0]      low_reg;
    logic [2:0][DQW-1:0]      quo_reg;

    logic [2:0][QW:0] cur;
    logic [2:0]       fits;

    // Compare each shifted remainder with the divisor.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cur[k]  = {rem_in[k], low_in[k][DQW-1]};
            fits[k] = (cur[k] >= {1'b0, q_in});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_in;
            for (int k = 0; k < 3; k++) begin
                rem_reg[k] <= fits[k] ? QW'(cur[k] - {1'b0, q_in}) : QW'(cur[k]);
                low_reg[k] <= low_in[k] << 1;
                quo_reg[k] <= {quo_in[k][DQW-2:0], fits[k]};
            end
        end
    end

    assign ctl_out = ctl_reg;
    assign q_out   = q_reg;
    assign rem_out = rem_reg;
    assign low_out = low_reg;
    assign quo_out = quo_reg;

endmodule

[hw/rtl/triangle_unit_normal_unit.sv]
// ----------------------------------------------------------------------------
// triangle_unit_normal_unit: unit normal of a triangle face
// Cross product of edges a - b and a - c, normalised to unit length in Q2.30.
// ----------------------------------------------------------------------------
// The block takes one face beat per clock while s_ready is high and
// returns one result beat per face, in order, through thirteen stages
// of cross product and block normalisation, a chain of 32 square-root
// cells, one numerator stage, a chain of NORMAL_FRAC_BITS + 1 divider
// cells and the output register. Most of the stages lie in those two
// cell chains, each cell settling one bit. A skid register behind the
// output register lets the pipeline keep moving while a result beat
// waits; s_ready falls only once both hold a beat.
// A face whose cross product is zero gives a zero normal with degenerate set.
module triangle_unit_normal_unit #(
    parameter int NORMAL_FRAC_BITS = tun_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tun_pkg::tun_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output tun_pkg::tun_out_t  m_data
);

    localparam int RB   = tun_pkg::RED_W;
    localparam int QW   = tun_pkg::ROOT_W;
    localparam int FB   = NORMAL_FRAC_BITS;
    localparam int DQW  = FB + 1;
    localparam int NUMW = RB + FB + 1;
    localparam int OW   = tun_pkg::OUT_W;
    localparam int NLIM = 1 << FB;

    logic en;

    // Front end.
    tun_pkg::tun_ctl_t           fr_ctl;
    logic [2:0][RB-1:0]          fr_r;
    logic [tun_pkg::SUM_W-1:0]   fr_s;

    tun_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (s_valid && en),
        .in_data (s_data),
        .ctl_out (fr_ctl),
        .r_out   (fr_r),
        .s_out   (fr_s)
    );

    // Square-root cell chain, one root bit per cell.
    tun_pkg::tun_ctl_t           sq_ctl  [QW+1];
    logic [tun_pkg::SUM_W-1:0]   sq_s    [QW+1];
    logic [QW+1:0]               sq_rem  [QW+1];
    logic [QW-1:0]               sq_root [QW+1];
    logic [2:0][RB-1:0]          sq_r    [QW+1];

    assign sq_ctl[0]  = fr_ctl;
    assign sq_s[0]    = fr_s;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_r[0]    = fr_r;

    for (genvar g = 0; g < QW; g++) begin : g_sqrt
        tun_sqrt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .ctl_in   (sq_ctl[g]),
            .s_in     (sq_s[g]),
            .rem_in   (sq_rem[g]),
            .root_in  (sq_root[g]),
            .r_in     (sq_r[g]),
            .ctl_out  (sq_ctl[g+1]),
            .s_out    (sq_s[g+1]),
            .rem_out  (sq_rem[g+1]),
            .root_out (sq_root[g+1]),
            .r_out    (sq_r[g+1])
        );
    end

    // Rounded numerators r * 2^FB + floor(q / 2).
    tun_pkg::tun_ctl_t      num_ctl_reg;
    logic [QW-1:0]          num_q_reg;
    logic [NUMW-1:0]        num_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_ctl_reg <= '0;
        end else if (en) begin
            num_ctl_reg <= sq_ctl[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_q_reg <= sq_root[QW];
            for (int k = 0; k < 3; k++) begin
                num_reg[k] <= (NUMW'(sq_r[QW][k]) << FB) + NUMW'(sq_root[QW] >> 1);
            end
        end
    end

    // Divider cell chain, one quotient bit per cell.
    tun_pkg::tun_ctl_t      dv_ctl [DQW+1];
    logic [QW-1:0]          dv_q   [DQW+1];
    logic [2:0][QW-1:0]     dv_rem [DQW+1];
    logic [2:0][DQW-1:0]    dv_low [DQW+1];
    logic [2:0][DQW-1:0]    dv_quo [DQW+1];

    assign dv_ctl[0] = num_ctl_reg;
    assign dv_q[0]   = num_q_reg;
    assign dv_quo[0] = '0;

    for (genvar k = 0; k < 3; k++) begin : g_num
        assign dv_rem[0][k] = {1'b0, num_reg[k][NUMW-1:DQW]};
        assign dv_low[0][k] = num_reg[k][DQW-1:0];
    end

    for (genvar g = 0; g < DQW; g++) begin : g_div
        tun_div_cell #(
            .NORMAL_FRAC_BITS (FB)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .ctl_in  (dv_ctl[g]),
            .q_in    (dv_q[g]),
            .rem_in  (dv_rem[g]),
            .low_in  (dv_low[g]),
            .quo_in  (dv_quo[g]),
            .ctl_out (dv_ctl[g+1]),
            .q_out   (dv_q[g+1]),
            .rem_out (dv_rem[g+1]),
            .low_out (dv_low[g+1]),
            .quo_out (dv_quo[g+1])
        );
    end

    // Clamp, sign and degenerate handling of the finished beat.
    tun_pkg::tun_out_t res;
    logic              res_vld;
    logic [OW-1:0]     comp [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            comp[k] = (dv_quo[DQW][k] > DQW'(NLIM)) ? OW'(NLIM) : OW'(dv_quo[DQW][k]);
            if (dv_ctl[DQW].degen) begin
                comp[k] = '0;
            end else if (dv_ctl[DQW].neg[k]) begin
                comp[k] = -comp[k];
            end
        end
        res.normal_x   = comp[0];
        res.normal_y   = comp[1];
        res.normal_z   = comp[2];
        res.degenerate = dv_ctl[DQW].degen;
        res_vld        = dv_ctl[DQW].valid;
    end

    // Output register with a skid register behind it.
    logic              m_vld_reg;
    logic              skid_vld_reg;
    tun_pkg::tun_out_t m_data_reg;
    tun_pkg::tun_out_t skid_reg;

    assign en      = !skid_vld_reg;
    assign s_ready = en;
    assign m_valid = m_vld_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg    <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (skid_vld_reg) begin
            if (m_ready) begin
                skid_vld_reg <= 1'b0;
            end
        end else if (res_vld) begin
            if (!m_vld_reg || m_ready) begin
                m_vld_reg <= 1'b1;
            end else begin
                skid_vld_reg <= 1'b1;
            end
        end else if (m_ready) begin
            m_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_vld_reg) begin
            if (m_ready) begin
                m_data_reg <= skid_reg;
            end
        end else if (res_vld) begin
            if (!m_vld_reg || m_ready) begin
                m_data_reg <= res;
            end else begin
                skid_reg <= res;
            end
        end
    end

    // The skid register only fills behind a waiting output beat.
    a_skid_behind_out : assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> m_vld_reg)
        else $error("skid register holds a beat with no output beat");

    // Input back-pressure only with a result beat waiting.
    a_ready_low : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !$past(m_ready)))
        else $error("input stalled with no result beat waiting");

    // A degenerate face gives the zero vector.
    a_degen_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.degenerate) |->
        (m_data.normal_x == '0 && m_data.normal_y == '0 && m_data.normal_z == '0))
        else $error("degenerate beat with non-zero normal");

    // Components stay within one unit.
    a_unit_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |->
        (m_data.normal_x <= NLIM && m_data.normal_x >= -NLIM &&
         m_data.normal_y <= NLIM && m_data.normal_y >= -NLIM &&
         m_data.normal_z <= NLIM && m_data.normal_z >= -NLIM))
        else $error("normal component beyond unit range");

endmodule
